// ----- hdl/jafp_pkg.sv -----
// ----------------------------------------------------------------------------
// jafp_pkg: shared constants and tables for the joint angle pipeline
// Widths of the normalized CORDIC datapath and the arctangent table.
// ----------------------------------------------------------------------------
package jafp_pkg;

   localparam int COORD_BITS_DEF = 14;
   localparam int NORM_BITS      = 30;
   localparam int CORDIC_ITERS   = 31;
   localparam int ANGLE_BITS     = 11;
   // cordic x/y width: |x|,|y| grow to about 2^31.7 after gain, keep margin
   localparam int CW             = 36;
   localparam int ZW             = 34;
   localparam int SQ_BITS        = 62;

   typedef logic signed [CW-1:0] cw_type;
   typedef logic signed [ZW-1:0] zw_type;

   function automatic logic [ZW-1:0] atan_entry(input int k);
      logic [ZW-1:0] r;
      case (k)
         0:  r = 34'd536870912;
         1:  r = 34'd316933406;
         2:  r = 34'd167458907;
         3:  r = 34'd85004756;
         4:  r = 34'd42667331;
         5:  r = 34'd21354465;
         6:  r = 34'd10679838;
         7:  r = 34'd5340245;
         8:  r = 34'd2670163;
         9:  r = 34'd1335087;
         10: r = 34'd667544;
         11: r = 34'd333772;
         12: r = 34'd166886;
         13: r = 34'd83443;
         14: r = 34'd41722;
         15: r = 34'd20861;
         16: r = 34'd10430;
         17: r = 34'd5215;
         18: r = 34'd2608;
         19: r = 34'd1304;
         20: r = 34'd652;
         21: r = 34'd326;
         22: r = 34'd163;
         23: r = 34'd81;
         24: r = 34'd41;
         25: r = 34'd20;
         26: r = 34'd10;
         27: r = 34'd5;
         28: r = 34'd3;
         29: r = 34'd1;
         30: r = 34'd1;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ----- hdl/jafp_sqrt_stage.sv -----
// ----------------------------------------------------------------------------
// jafp_sqrt_stage: one registered step of the restoring integer square root
// Resolves one result bit per stage, with valid and side data alongside.
// ----------------------------------------------------------------------------
module jafp_sqrt_stage #(
   parameter int STEP = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              valid_in,
   input  logic [jafp_pkg::SQ_BITS-1:0]      rem_in,
   input  logic [jafp_pkg::SQ_BITS/2-1:0]    root_in,
   input  logic signed [jafp_pkg::CW-1:0]    x_in,
   input  logic                              degen_in,
   output logic                              valid_out,
   output logic [jafp_pkg::SQ_BITS-1:0]      rem_out,
   output logic [jafp_pkg::SQ_BITS/2-1:0]    root_out,
   output logic signed [jafp_pkg::CW-1:0]    x_out,
   output logic                              degen_out
);
   import jafp_pkg::*;

   localparam int RB  = SQ_BITS / 2;
   localparam int POS = RB - 1 - STEP;

   logic              valid_ff;
   logic [SQ_BITS-1:0] rem_ff, rem_in_w;
   logic [RB-1:0]      root_ff, root_in_w;
   cw_type             x_ff;
   logic               degen_ff;
   logic [SQ_BITS+1:0] trial;
   logic [SQ_BITS+1:0] rem_wide;

   // trial = (root << (POS+1)) + 4^POS
   always_comb begin
      trial    = ({{(SQ_BITS+2-RB){1'b0}}, root_in} << (POS + 1))
               + ({{(SQ_BITS+1){1'b0}}, 1'b1} << (2 * POS));
      rem_wide = {2'b00, rem_in};
      if (rem_wide >= trial) begin
         rem_in_w  = rem_in - trial[SQ_BITS-1:0];
         root_in_w = root_in | (RB'(1) << POS);
      end else begin
         rem_in_w  = rem_in;
         root_in_w = root_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      rem_ff   <= rem_in_w;
      root_ff  <= root_in_w;
      x_ff     <= x_in;
      degen_ff <= degen_in;
   end

   assign valid_out = valid_ff;
   assign rem_out   = rem_ff;
   assign root_out  = root_ff;
   assign x_out     = x_ff;
   assign degen_out = degen_ff;
endmodule

// ----- hdl/jafp_cordic_stage.sv -----
// ----------------------------------------------------------------------------
// jafp_cordic_stage: one registered vectoring CORDIC iteration
// Rotates toward the x axis by atan(2^-STEP) and accumulates the angle.
// ----------------------------------------------------------------------------
module jafp_cordic_stage #(
   parameter int STEP = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           valid_in,
   input  logic signed [jafp_pkg::CW-1:0] x_in,
   input  logic signed [jafp_pkg::CW-1:0] y_in,
   input  logic signed [jafp_pkg::ZW-1:0] z_in,
   input  logic                           degen_in,
   output logic                           valid_out,
   output logic signed [jafp_pkg::CW-1:0] x_out,
   output logic signed [jafp_pkg::CW-1:0] y_out,
   output logic signed [jafp_pkg::ZW-1:0] z_out,
   output logic                           degen_out
);
   import jafp_pkg::*;

   localparam logic [ZW-1:0] ATAN = atan_entry(STEP);

   logic   valid_ff, degen_ff;
   cw_type x_ff, y_ff, x_in_w, y_in_w, dx, dy;
   zw_type z_ff, z_in_w;

   always_comb begin
      dx = y_in >>> STEP;
      dy = x_in >>> STEP;
      if (y_in > 0) begin
         x_in_w = x_in + dx;
         y_in_w = y_in - dy;
         z_in_w = z_in + $signed(ATAN);
      end else begin
         x_in_w = x_in - dx;
         y_in_w = y_in + dy;
         z_in_w = z_in - $signed(ATAN);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      x_ff     <= x_in_w;
      y_ff     <= y_in_w;
      z_ff     <= z_in_w;
      degen_ff <= degen_in;
   end

   assign valid_out = valid_ff;
   assign x_out     = x_ff;
   assign y_out     = y_ff;
   assign z_out     = z_ff;
   assign degen_out = degen_ff;
endmodule

// ----- hdl/joint_angle_from_three_points.sv -----
// ----------------------------------------------------------------------------
// joint_angle_from_three_points: angle at a vertex joint between two joints
// Fully pipelined cross/dot product, normalize, square root and CORDIC.
// ----------------------------------------------------------------------------
// Usage: drive the nine coordinates on req_* and pulse start; busy is tied
// low, so a request is taken in every cycle that start is high. Each request
// yields exactly one response: rsp_valid is high for one cycle with
// rsp_angle_tenths (0..1800 tenths of a degree, rounded) and rsp_degenerate
// (set, with angle 0, when either difference vector is zero).
// Throughput is one request per cycle. The pipe has 73 register stages: the
// difference, product, sum, bit-length, normalize, square and sum-of-squares
// registers, 31 square root bit stages, the pre-rotation register, 31 CORDIC
// iteration stages and the clamp, scale and output registers; the depth is
// set by the one-bit-per-stage root and the one-iteration-per-stage CORDIC.
// Responses leave in request order. Reset clears every valid bit, dropping
// requests in flight. The receiver cannot stall, so the pipe never holds.
// ----------------------------------------------------------------------------
module joint_angle_from_three_points #(
   parameter int COORD_BITS = jafp_pkg::COORD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [COORD_BITS-1:0]      req_vertex_x,
   input  logic signed [COORD_BITS-1:0]      req_vertex_y,
   input  logic signed [COORD_BITS-1:0]      req_vertex_z,
   input  logic signed [COORD_BITS-1:0]      req_first_x,
   input  logic signed [COORD_BITS-1:0]      req_first_y,
   input  logic signed [COORD_BITS-1:0]      req_first_z,
   input  logic signed [COORD_BITS-1:0]      req_second_x,
   input  logic signed [COORD_BITS-1:0]      req_second_y,
   input  logic signed [COORD_BITS-1:0]      req_second_z,
   output logic                              rsp_valid,
   output logic [jafp_pkg::ANGLE_BITS-1:0]   rsp_angle_tenths,
   output logic                              rsp_degenerate
);
   import jafp_pkg::*;

   localparam int DW = COORD_BITS + 1;        // difference width
   localparam int PW = 2 * DW;                // product width
   localparam int SW = PW + 2;                // sum of three products
   localparam int LW = $clog2(SW + 1);        // bit-length width
   localparam int RB = SQ_BITS / 2;

   // stage 1: differences
   logic s1_v_ff;
   logic signed [DW-1:0] ux_ff, uy_ff, uz_ff, wx_ff, wy_ff, wz_ff;
   // stage 2: products
   logic s2_v_ff, s2_dg_ff;
   logic signed [PW-1:0] p_ff [9];
   // stage 3: sums
   logic s3_v_ff, s3_dg_ff;
   logic signed [SW-1:0] c3_ff [4];
   // stage 4: magnitudes or-ed to find bit length
   logic s4_v_ff, s4_dg_ff;
   logic signed [SW-1:0] c4_ff [4];
   logic [LW-1:0] len4_ff;
   // stage 5: normalized values
   logic s5_v_ff, s5_dg_ff;
   logic signed [NORM_BITS:0] n5_ff [4];
   // stage 6: squares
   logic s6_v_ff, s6_dg_ff;
   logic [SQ_BITS-1:0] sq6_ff [3];
   cw_type x6_ff;
   // stage 7: sum of squares
   logic s7_v_ff, s7_dg_ff;
   logic [SQ_BITS-1:0] sum7_ff;
   cw_type x7_ff;

   logic degen_w;
   logic [SW-1:0] mag_or;
   logic [LW-1:0] len_w;

   assign busy = 1'b0;

   always_comb begin
      degen_w = (ux_ff == '0 && uy_ff == '0 && uz_ff == '0) ||
                (wx_ff == '0 && wy_ff == '0 && wz_ff == '0);
   end

   always_comb begin
      mag_or = '0;
      for (int i = 0; i < 4; i++) begin
         mag_or = mag_or | (c3_ff[i][SW-1] ? SW'(-c3_ff[i]) : SW'(c3_ff[i]));
      end
      len_w = '0;
      for (int i = 0; i < SW; i++) begin
         if (mag_or[i]) len_w = LW'(i + 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
         s6_v_ff <= 1'b0;
         s7_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= start;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         s5_v_ff <= s4_v_ff;
         s6_v_ff <= s5_v_ff;
         s7_v_ff <= s6_v_ff;
      end
      ux_ff <= DW'(req_first_x) - DW'(req_vertex_x);
      uy_ff <= DW'(req_first_y) - DW'(req_vertex_y);
      uz_ff <= DW'(req_first_z) - DW'(req_vertex_z);
      wx_ff <= DW'(req_second_x) - DW'(req_vertex_x);
      wy_ff <= DW'(req_second_y) - DW'(req_vertex_y);
      wz_ff <= DW'(req_second_z) - DW'(req_vertex_z);

      s2_dg_ff <= degen_w;
      p_ff[0] <= uy_ff * wz_ff;
      p_ff[1] <= uz_ff * wy_ff;
      p_ff[2] <= uz_ff * wx_ff;
      p_ff[3] <= ux_ff * wz_ff;
      p_ff[4] <= ux_ff * wy_ff;
      p_ff[5] <= uy_ff * wx_ff;
      p_ff[6] <= ux_ff * wx_ff;
      p_ff[7] <= uy_ff * wy_ff;
      p_ff[8] <= uz_ff * wz_ff;

      s3_dg_ff <= s2_dg_ff;
      c3_ff[0] <= SW'(p_ff[0]) - SW'(p_ff[1]);
      c3_ff[1] <= SW'(p_ff[2]) - SW'(p_ff[3]);
      c3_ff[2] <= SW'(p_ff[4]) - SW'(p_ff[5]);
      c3_ff[3] <= SW'(p_ff[6]) + SW'(p_ff[7]) + SW'(p_ff[8]);

      s4_dg_ff <= s3_dg_ff;
      c4_ff    <= c3_ff;
      len4_ff  <= len_w;

      s5_dg_ff <= s4_dg_ff;
      for (int i = 0; i < 4; i++) begin
         if (len4_ff > LW'(NORM_BITS))
            n5_ff[i] <= (NORM_BITS+1)'(c4_ff[i] >>> (len4_ff - LW'(NORM_BITS)));
         else
            n5_ff[i] <= (NORM_BITS+1)'(c4_ff[i]) <<< (LW'(NORM_BITS) - len4_ff);
      end

      s6_dg_ff <= s5_dg_ff;
      for (int i = 0; i < 3; i++) begin
         sq6_ff[i] <= $unsigned(SQ_BITS'(n5_ff[i]) * SQ_BITS'(n5_ff[i]));
      end
      x6_ff <= CW'(n5_ff[3]);

      s7_dg_ff <= s6_dg_ff;
      sum7_ff  <= sq6_ff[0] + sq6_ff[1] + sq6_ff[2];
      x7_ff    <= x6_ff;
   end

   // square root, one bit per stage
   logic               sv [RB+1];
   logic [SQ_BITS-1:0] srem [RB+1];
   logic [RB-1:0]      sroot [RB+1];
   cw_type             sx [RB+1];
   logic               sdg [RB+1];

   assign sv[0]    = s7_v_ff;
   assign srem[0]  = sum7_ff;
   assign sroot[0] = '0;
   assign sx[0]    = x7_ff;
   assign sdg[0]   = s7_dg_ff;

   for (genvar g = 0; g < RB; g++) begin : g_sqrt
      jafp_sqrt_stage #(.STEP(g)) u_sq (
         .clock(clock), .reset(reset),
         .valid_in(sv[g]), .rem_in(srem[g]), .root_in(sroot[g]),
         .x_in(sx[g]), .degen_in(sdg[g]),
         .valid_out(sv[g+1]), .rem_out(srem[g+1]), .root_out(sroot[g+1]),
         .x_out(sx[g+1]), .degen_out(sdg[g+1])
      );
   end

   // pre-rotation for the left half plane
   logic   pr_v_ff, pr_dg_ff;
   cw_type pr_x_ff, pr_y_ff;
   zw_type pr_z_ff;
   cw_type yroot;
   assign yroot = CW'(sroot[RB]);

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_v_ff <= 1'b0;
      end else begin
         pr_v_ff <= sv[RB];
      end
      pr_dg_ff <= sdg[RB];
      if (sx[RB] < 0) begin
         pr_x_ff <= yroot;
         pr_y_ff <= -sx[RB];
         pr_z_ff <= ZW'(1) <<< 30;
      end else begin
         pr_x_ff <= sx[RB];
         pr_y_ff <= yroot;
         pr_z_ff <= '0;
      end
   end

   logic   cv [CORDIC_ITERS+1];
   cw_type cx [CORDIC_ITERS+1];
   cw_type cy [CORDIC_ITERS+1];
   zw_type cz [CORDIC_ITERS+1];
   logic   cdg [CORDIC_ITERS+1];

   assign cv[0]  = pr_v_ff;
   assign cx[0]  = pr_x_ff;
   assign cy[0]  = pr_y_ff;
   assign cz[0]  = pr_z_ff;
   assign cdg[0] = pr_dg_ff;

   for (genvar g = 0; g < CORDIC_ITERS; g++) begin : g_cordic
      jafp_cordic_stage #(.STEP(g)) u_cs (
         .clock(clock), .reset(reset),
         .valid_in(cv[g]), .x_in(cx[g]), .y_in(cy[g]), .z_in(cz[g]),
         .degen_in(cdg[g]),
         .valid_out(cv[g+1]), .x_out(cx[g+1]), .y_out(cy[g+1]), .z_out(cz[g+1]),
         .degen_out(cdg[g+1])
      );
   end

   // clamp, scale by 3600 and round
   logic        cl_v_ff, cl_dg_ff, sc_v_ff, sc_dg_ff, out_v_ff, out_dg_ff;
   logic [31:0] cl_z_ff;
   logic [43:0] sc_ff;
   logic [ANGLE_BITS-1:0] out_a_ff;
   zw_type zf;
   assign zf = cz[CORDIC_ITERS];

   always_ff @(posedge clock) begin
      if (reset) begin
         cl_v_ff  <= 1'b0;
         sc_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         cl_v_ff  <= cv[CORDIC_ITERS];
         sc_v_ff  <= cl_v_ff;
         out_v_ff <= sc_v_ff;
      end
      cl_dg_ff <= cdg[CORDIC_ITERS];
      if (zf < 0)
         cl_z_ff <= '0;
      else if (zf > (ZW'(1) <<< 31))
         cl_z_ff <= 32'h8000_0000;
      else
         cl_z_ff <= zf[31:0];
      sc_dg_ff <= cl_dg_ff;
      sc_ff    <= {12'd0, cl_z_ff} * 44'd3600 + 44'h0_8000_0000;
      out_dg_ff <= sc_dg_ff;
      out_a_ff  <= sc_dg_ff ? '0 : sc_ff[32 +: ANGLE_BITS];
   end

   assign rsp_valid        = out_v_ff;
   assign rsp_angle_tenths = out_a_ff;
   assign rsp_degenerate   = out_dg_ff;
endmodule

// ----- hdl/jafp_checker.sv -----
// ----------------------------------------------------------------------------
// jafp_checker: port-level checks on the joint angle block
// Watches the response range and the fixed request-to-response latency.
// ----------------------------------------------------------------------------
module jafp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            rsp_valid,
   input logic [jafp_pkg::ANGLE_BITS-1:0] rsp_angle_tenths,
   input logic                            rsp_degenerate
);
   import jafp_pkg::*;

   // edges from the accepting edge to the edge that takes the response
   localparam int LAT = 73;

   a_busy_low: assert property (@(posedge clock) busy == 1'b0)
      else $error("busy raised");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_angle_tenths <= ANGLE_BITS'(1800))
      else $error("angle out of range");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_angle_tenths == '0)
      else $error("degenerate angle not zero");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LAT rsp_valid)
      else $error("response missing after request");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(reset, 2))
      else $error("response right after reset");
endmodule

bind joint_angle_from_three_points jafp_checker u_jafp_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_angle_tenths(rsp_angle_tenths),
   .rsp_degenerate(rsp_degenerate)
);
